/* sv/dllm_pkg.sv */
// Shared types and constants for the doubly linked list manager.
// Holds the request and response transaction structs and the opcode set.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dllm_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int NodeWidth   = 6;
   localparam int OpWidth     = 3;
   localparam int LengthWidth = 7;

   // Default pool size and the width used to compare slot indexes with it.
   localparam int NodeSlotsDefault = 64;
   localparam int SlotCmpWidth     = 13;

   // Request opcodes; the two remaining codes are illegal.
   typedef enum logic [OpWidth-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_APPEND     = 3'd1,
      OP_INSERT     = 3'd2,
      OP_REMOVE     = 3'd3,
      OP_POP        = 3'd4,
      OP_CONTAINS   = 3'd5
   } op_type;

   typedef struct packed {
      logic [OpWidth-1:0]   op;
      logic [NodeWidth-1:0] node;
      logic [NodeWidth-1:0] anchor;
   } req_type;

   typedef struct packed {
      logic [NodeWidth-1:0]   popped_node;
      logic                   found;
      logic                   error;
      logic [LengthWidth-1:0] length;
      logic                   is_empty;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/dllm_link_ram.sv */
// Link memory: one write port and one read port with registered read data.
// Used twice, once for the next links and once for the prev links.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dllm_link_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 7
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Synchronous write and read; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* sv/doubly_linked_list_manager.sv */
// Doubly linked list manager: one list over a pool of node slots.
// Depends on dllm_pkg and dllm_link_ram (next and prev link memories).
//
//   Channel   Ports                  Direction  Handshake
//   request   start, busy, req_data  in         taken when start is high and busy low
//   response  rsp_strobe, rsp_data   out        valid for one cycle, cannot be held off
//
// A request that links or unlinks a node runs in steps: the accept cycle issues the
// link memory read, ST_LINK captures the neighbor links, and ST_WR_A and ST_WR_B
// write the link memories, since each memory has one write port.
// The response strobe comes in the cycle after the last write, when busy is
// already low. Illegal requests and contains requests answer in the cycle after
// they are taken. Reset is synchronous; the link memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module doubly_linked_list_manager #(
   parameter int NODE_SLOTS = dllm_pkg::NodeSlotsDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire dllm_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output dllm_pkg::rsp_type      rsp_data
);

   import dllm_pkg::*;

   // Only slots that the node field can name are ever stored.
   localparam int MaxAddressable = 1 << NodeWidth;
   localparam int MemDepth = (NODE_SLOTS < MaxAddressable) ? NODE_SLOTS : MaxAddressable;
   localparam int AddrW    = $clog2(MemDepth);
   localparam int LinkW    = $clog2(NODE_SLOTS + 1);
   localparam logic [LinkW-1:0] NoneLink = LinkW'(NODE_SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LINK,
      ST_WR_A,
      ST_WR_B
   } state_type;

   state_type          state_ff;
   logic [LinkW-1:0]   first_ff;
   logic [LinkW-1:0]   last_ff;
   logic [LinkW-1:0]   count_ff;
   logic [MemDepth-1:0] in_list_ff;

   logic [OpWidth-1:0] op_ff;
   logic               insert_ff;
   logic [LinkW-1:0]   n_ff;
   logic [LinkW-1:0]   anchor_ff;
   logic [LinkW-1:0]   p_ff;
   logic [LinkW-1:0]   q_ff;

   logic               rsp_strobe_ff;
   rsp_type            rsp_ff;

   // Link memory ports.
   logic               next_wr_en;
   logic [AddrW-1:0]   next_wr_addr;
   logic [LinkW-1:0]   next_wr_data;
   logic               prev_wr_en;
   logic [AddrW-1:0]   prev_wr_addr;
   logic [LinkW-1:0]   prev_wr_data;
   logic [AddrW-1:0]   rd_addr;
   logic [LinkW-1:0]   next_rd;
   logic [LinkW-1:0]   prev_rd;

   // Request checks.
   logic               node_ok;
   logic               anchor_ok;
   logic               node_in;
   logic               anchor_in;
   logic               err_now;
   logic               found_now;
   logic               is_insert;
   logic               p_valid;
   logic               q_valid;
   logic [LinkW-1:0]   count_in;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Membership lookup of the requested node and anchor.
   always_comb begin
      node_ok   = {{(SlotCmpWidth-NodeWidth){1'b0}}, req_data.node}
                  < SlotCmpWidth'(NODE_SLOTS);
      anchor_ok = {{(SlotCmpWidth-NodeWidth){1'b0}}, req_data.anchor}
                  < SlotCmpWidth'(NODE_SLOTS);
      node_in   = node_ok && in_list_ff[req_data.node[AddrW-1:0]];
      anchor_in = anchor_ok && in_list_ff[req_data.anchor[AddrW-1:0]];
   end

   // Legality of the request against the current list state.
   always_comb begin
      err_now   = 1'b0;
      found_now = 1'b0;
      is_insert = 1'b0;
      unique case (op_type'(req_data.op))
         OP_PUSH_FRONT, OP_APPEND: begin
            err_now   = !node_ok || node_in;
            is_insert = 1'b1;
         end
         OP_INSERT: begin
            err_now   = !node_ok || node_in || !anchor_in;
            is_insert = 1'b1;
         end
         OP_REMOVE: begin
            err_now = !node_in;
         end
         OP_POP: begin
            err_now = (first_ff == NoneLink);
         end
         OP_CONTAINS: begin
            found_now = node_in;
         end
         default: begin
            err_now = 1'b1;
         end
      endcase
   end

   // Read address: the anchor's prev link, or both links of the node to unlink.
   always_comb begin
      unique if (op_type'(req_data.op) == OP_INSERT) begin
         rd_addr = req_data.anchor[AddrW-1:0];
      end else if (op_type'(req_data.op) == OP_POP) begin
         rd_addr = first_ff[AddrW-1:0];
      end else begin
         rd_addr = req_data.node[AddrW-1:0];
      end
   end

   assign p_valid = (p_ff != NoneLink);
   assign q_valid = (q_ff != NoneLink);

   // Link memory writes. An insert writes the new node first and its neighbors
   // second; an unlink joins the two neighbors in the first write cycle.
   always_comb begin
      next_wr_en   = 1'b0;
      next_wr_addr = n_ff[AddrW-1:0];
      next_wr_data = q_ff;
      prev_wr_en   = 1'b0;
      prev_wr_addr = n_ff[AddrW-1:0];
      prev_wr_data = p_ff;
      unique case (state_ff)
         ST_WR_A: begin
            if (insert_ff) begin
               next_wr_en = 1'b1;
               prev_wr_en = 1'b1;
            end else begin
               next_wr_en   = p_valid;
               next_wr_addr = p_ff[AddrW-1:0];
               prev_wr_en   = q_valid;
               prev_wr_addr = q_ff[AddrW-1:0];
            end
         end
         ST_WR_B: begin
            if (insert_ff) begin
               next_wr_en   = p_valid;
               next_wr_addr = p_ff[AddrW-1:0];
               next_wr_data = n_ff;
               prev_wr_en   = q_valid;
               prev_wr_addr = q_ff[AddrW-1:0];
               prev_wr_data = n_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign count_in = insert_ff ? (count_ff + LinkW'(1)) : (count_ff - LinkW'(1));

   // Sequencer, list head and tail, membership bits, count and response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_ff      <= NoneLink;
         last_ff       <= NoneLink;
         count_ff      <= '0;
         in_list_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff     <= req_data.op;
                  insert_ff <= is_insert;
                  anchor_ff <= LinkW'(req_data.anchor);
                  n_ff      <= (op_type'(req_data.op) == OP_POP)
                               ? first_ff : LinkW'(req_data.node);
                  if (err_now || op_type'(req_data.op) == OP_CONTAINS) begin
                     rsp_strobe_ff      <= 1'b1;
                     rsp_ff.popped_node <= '0;
                     rsp_ff.found       <= found_now;
                     rsp_ff.error       <= err_now;
                     rsp_ff.length      <= LengthWidth'(count_ff);
                     rsp_ff.is_empty    <= (count_ff == '0);
                  end else begin
                     rsp_strobe_ff <= 1'b0;
                     state_ff      <= ST_LINK;
                  end
               end else begin
                  rsp_strobe_ff <= 1'b0;
               end
            end
            ST_LINK: begin
               // Neighbors of the node being linked or unlinked.
               unique case (op_type'(op_ff))
                  OP_PUSH_FRONT: begin
                     p_ff <= NoneLink;
                     q_ff <= first_ff;
                  end
                  OP_APPEND: begin
                     p_ff <= last_ff;
                     q_ff <= NoneLink;
                  end
                  OP_INSERT: begin
                     p_ff <= prev_rd;
                     q_ff <= anchor_ff;
                  end
                  default: begin
                     p_ff <= prev_rd;
                     q_ff <= next_rd;
                  end
               endcase
               rsp_strobe_ff <= 1'b0;
               state_ff      <= ST_WR_A;
            end
            ST_WR_A: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= ST_WR_B;
            end
            ST_WR_B: begin
               if (insert_ff) begin
                  if (!p_valid) begin
                     first_ff <= n_ff;
                  end
                  if (!q_valid) begin
                     last_ff <= n_ff;
                  end
               end else begin
                  if (!p_valid) begin
                     first_ff <= q_ff;
                  end
                  if (!q_valid) begin
                     last_ff <= p_ff;
                  end
               end
               in_list_ff[n_ff[AddrW-1:0]] <= insert_ff;
               count_ff           <= count_in;
               rsp_strobe_ff      <= 1'b1;
               rsp_ff.popped_node <= (op_type'(op_ff) == OP_POP) ? NodeWidth'(n_ff) : '0;
               rsp_ff.found       <= 1'b0;
               rsp_ff.error       <= 1'b0;
               rsp_ff.length      <= LengthWidth'(count_in);
               rsp_ff.is_empty    <= (count_in == '0);
               state_ff           <= ST_IDLE;
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
         endcase
      end
   end

   dllm_link_ram #(
      .DEPTH (MemDepth),
      .WIDTH (LinkW)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   dllm_link_ram #(
      .DEPTH (MemDepth),
      .WIDTH (LinkW)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the doubly linked list manager.
// Depends on dllm_pkg and the doubly_linked_list_manager RTL. A driver feeds
// requests and a monitor checks every response against a behavioral list predictor.
`timescale 1ns / 1ps

module tb;
   import dllm_pkg::*;

   localparam int HalfPeriod  = 4;
   localparam int ResetCycles = 9;
   localparam int RandomItems = 650;
   localparam int DrainCycles = 8;
   localparam int StallLimit  = 400;

   // Pool size and the link value that means "no node".
   localparam int Slots = NodeSlotsDefault;
   typedef logic [LengthWidth-1:0] link_t;
   typedef logic [NodeWidth-1:0]   slot_t;
   localparam link_t NoNode = link_t'(Slots);

   // The two opcodes that the package leaves unassigned.
   localparam logic [OpWidth-1:0] OpIllegalLow  = 3'd6;
   localparam logic [OpWidth-1:0] OpIllegalHigh = 3'd7;

   // Full list state: links per slot, membership bits, ends and length.
   typedef struct packed {
      link_t [Slots-1:0] next_slot;
      link_t [Slots-1:0] prev_slot;
      logic  [Slots-1:0] member;
      link_t             head;
      link_t             tail;
      link_t             count;
   } list_state_t;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Requests waiting to be driven and responses waiting to arrive.
   req_type req_backlog[$];
   rsp_type pending_rsp[$];

   // The plan copy shapes the stimulus; the live copy predicts responses.
   list_state_t list_plan = '0;
   list_state_t list_now  = '0;

   logic        req_taken    = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned failures     = 0;
   int unsigned n_items      = 0;
   int unsigned n_illegal    = 0;
   int unsigned n_pops       = 0;
   int unsigned n_hits       = 0;
   int unsigned peak_len     = 0;
   int unsigned gap_left     = 0;
   int unsigned burst_left   = 1;

   doubly_linked_list_manager u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #HalfPeriod clock = ~clock;

   // Link slot n, not yet a member, between p and q; either may be none.
   function automatic void link_node(inout list_state_t s, input link_t p,
                                     input link_t n, input link_t q);
      s.prev_slot[n[NodeWidth-1:0]] = p;
      s.next_slot[n[NodeWidth-1:0]] = q;
      if (p < NoNode) s.next_slot[p[NodeWidth-1:0]] = n;
      else s.head = n;
      if (q < NoNode) s.prev_slot[q[NodeWidth-1:0]] = n;
      else s.tail = n;
      s.member[n[NodeWidth-1:0]] = 1'b1;
      s.count = s.count + 1'b1;
   endfunction

   // Unlink slot n, which is a member.
   function automatic void unlink_node(inout list_state_t s, input link_t n);
      link_t p;
      link_t q;
      p = s.prev_slot[n[NodeWidth-1:0]];
      q = s.next_slot[n[NodeWidth-1:0]];
      if (p < NoNode) s.next_slot[p[NodeWidth-1:0]] = q;
      else s.head = q;
      if (q < NoNode) s.prev_slot[q[NodeWidth-1:0]] = p;
      else s.tail = p;
      s.member[n[NodeWidth-1:0]] = 1'b0;
      s.count = s.count - 1'b1;
   endfunction

   // Apply one request to a list state and return the response it yields.
   // With 64 slots every 6-bit index names a real slot, so no range check.
   function automatic rsp_type list_step(inout list_state_t s, input req_type r);
      rsp_type rsp;
      link_t   nd;
      logic    node_in;
      rsp     = '0;
      nd      = link_t'(r.node);
      node_in = s.member[r.node];
      case (r.op)
         OP_PUSH_FRONT: begin
            if (node_in) rsp.error = 1'b1;
            else link_node(s, NoNode, nd, s.head);
         end
         OP_APPEND: begin
            if (node_in) rsp.error = 1'b1;
            else link_node(s, s.tail, nd, NoNode);
         end
         OP_INSERT: begin
            // A node equal to its anchor fails one of the two membership tests.
            if (node_in || !s.member[r.anchor]) rsp.error = 1'b1;
            else link_node(s, s.prev_slot[r.anchor], nd, link_t'(r.anchor));
         end
         OP_REMOVE: begin
            if (!node_in) rsp.error = 1'b1;
            else unlink_node(s, nd);
         end
         OP_POP: begin
            if (s.head == NoNode) begin
               rsp.error = 1'b1;
            end else begin
               rsp.popped_node = s.head[NodeWidth-1:0];
               unlink_node(s, s.head);
            end
         end
         OP_CONTAINS: rsp.found = node_in;
         default: rsp.error = 1'b1;
      endcase
      rsp.length   = s.count;
      rsp.is_empty = (s.count == '0);
      return rsp;
   endfunction

   // Pick a random slot whose membership matches; any slot if none does.
   function automatic slot_t pick_slot(input list_state_t s, input logic want_member);
      int unsigned first;
      slot_t       idx;
      first = $urandom_range(0, Slots - 1);
      for (int unsigned i = 0; i < Slots; i++) begin
         idx = slot_t'((first + i) % Slots);
         if (s.member[idx] == want_member) return idx;
      end
      return slot_t'(first);
   endfunction

   // Queue one request and advance the plan copy of the list.
   task automatic queue_req(input logic [OpWidth-1:0] op, input slot_t nd, input slot_t an);
      req_type r;
      r.op     = op;
      r.node   = nd;
      r.anchor = an;
      req_backlog.push_back(r);
      void'(list_step(list_plan, r));
   endtask

   task automatic report_mismatch(input string field, input logic [7:0] want,
                                  input logic [7:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      failures++;
   endtask

   // Driver: sends requests in bursts of random length with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_data <= req_backlog.pop_front();
            start    <= 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks each response, then predicts for a newly taken request.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      req_taken = 1'b0;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_strobe === 1'b1) begin
            quiet_cycles = 0;
            got = rsp_data;
            if (pending_rsp.size() == 0) begin
               $display("%0t: response with no request outstanding, got %p", $time, got);
               failures++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.popped_node !== want.popped_node)
                  report_mismatch("popped_node", 8'(want.popped_node), 8'(got.popped_node));
               if (got.found !== want.found)
                  report_mismatch("found", 8'(want.found), 8'(got.found));
               if (got.error !== want.error)
                  report_mismatch("error", 8'(want.error), 8'(got.error));
               if (got.length !== want.length)
                  report_mismatch("length", 8'(want.length), 8'(got.length));
               if (got.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 8'(want.is_empty), 8'(got.is_empty));
            end
         end
         if (start && !busy) begin
            req_taken    = 1'b1;
            quiet_cycles = 0;
            want = list_step(list_now, req_data);
            pending_rsp.push_back(want);
            n_items++;
            if (want.error) n_illegal++;
            if (req_data.op == OP_POP && !want.error) n_pops++;
            if (want.found) n_hits++;
            if (want.length > peak_len) peak_len = want.length;
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   initial begin
      while (quiet_cycles < StallLimit) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("FAILURE");
      $finish;
   end

   // Stimulus, reset and end of run.
   initial begin
      int unsigned   n_rand;
      int unsigned   seg_len;
      int unsigned   roll;
      int unsigned   pick;
      logic          grow;
      logic [OpWidth-1:0] op;
      slot_t         nd;
      slot_t         an;

      list_plan.head = NoNode;
      list_plan.tail = NoNode;
      list_now.head  = NoNode;
      list_now.tail  = NoNode;

      // Directed part: empty-list errors, each insert kind, duplicates,
      // removal at head, middle and tail, and the unused opcodes.
      queue_req(OP_POP, 6'd0, 6'd0);
      queue_req(OP_REMOVE, 6'd0, 6'd63);
      queue_req(OP_CONTAINS, 6'd63, 6'd0);
      queue_req(OP_INSERT, 6'd3, 6'd9);
      queue_req(OP_PUSH_FRONT, 6'd0, 6'd63);
      queue_req(OP_APPEND, 6'd63, 6'd0);
      queue_req(OP_INSERT, 6'd5, 6'd0);
      queue_req(OP_INSERT, 6'd42, 6'd63);
      queue_req(OP_INSERT, 6'd21, 6'd21);
      queue_req(OP_INSERT, 6'd42, 6'd42);
      queue_req(OP_PUSH_FRONT, 6'd0, 6'd0);
      queue_req(OP_APPEND, 6'd63, 6'd0);
      queue_req(OP_INSERT, 6'd0, 6'd63);
      queue_req(OP_CONTAINS, 6'd42, 6'd0);
      queue_req(OP_CONTAINS, 6'd1, 6'd63);
      queue_req(OpIllegalLow, 6'd63, 6'd63);
      queue_req(OpIllegalHigh, 6'd0, 6'd42);
      queue_req(OP_REMOVE, 6'd42, 6'd0);
      queue_req(OP_REMOVE, 6'd5, 6'd0);
      queue_req(OP_REMOVE, 6'd63, 6'd0);
      queue_req(OP_POP, 6'd63, 6'd63);
      queue_req(OP_POP, 6'd0, 6'd0);
      queue_req(OP_APPEND, 6'd63, 6'd0);
      queue_req(OP_REMOVE, 6'd63, 6'd63);

      // Random part: alternating grow and shrink phases. The first grow phase
      // is long enough to fill the pool; most requests are well formed.
      n_rand  = 0;
      grow    = 1'b1;
      seg_len = 110;
      while (n_rand < RandomItems) begin
         for (int unsigned k = 0; k < seg_len && n_rand < RandomItems; k++) begin
            roll = $urandom_range(0, 99);
            nd   = slot_t'($urandom_range(0, Slots - 1));
            an   = slot_t'($urandom_range(0, Slots - 1));
            if (roll < 2) begin
               op = (roll == 0) ? OpIllegalLow : OpIllegalHigh;
            end else if (roll < (grow ? 87 : 12)) begin
               pick = $urandom_range(0, 2);
               op   = (pick == 0) ? OP_PUSH_FRONT : (pick == 1) ? OP_APPEND : OP_INSERT;
               if ($urandom_range(0, 9) != 0) nd = pick_slot(list_plan, 1'b0);
               if ($urandom_range(0, 9) != 0) an = pick_slot(list_plan, 1'b1);
            end else if (roll < (grow ? 93 : 57)) begin
               op = OP_REMOVE;
               if ($urandom_range(0, 6) != 0) nd = pick_slot(list_plan, 1'b1);
            end else if (roll < (grow ? 96 : 90)) begin
               op = OP_POP;
            end else begin
               op = OP_CONTAINS;
               if ($urandom_range(0, 1) != 0) nd = pick_slot(list_plan, 1'b1);
            end
            queue_req(op, nd, an);
            n_rand++;
         end
         grow    = !grow;
         seg_len = $urandom_range(40, 110);
      end

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every response to arrive.
      while (req_backlog.size() != 0 || start || pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Checked %0d requests: %0d illegal, %0d pops, %0d contains hits.",
               n_items, n_illegal, n_pops, n_hits);
      $display("Longest list reached %0d of %0d slots.", peak_len, Slots);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", failures);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
sv/dllm_pkg.sv
sv/dllm_link_ram.sv
sv/doubly_linked_list_manager.sv
tb/sv/tb.sv
